// ===== sv/button_mode_autorepeat_assert.svh =====
// Assertion macros for the button mode and auto-repeat port checker.
`ifndef BUTTON_MODE_AUTOREPEAT_ASSERT_SVH
`define BUTTON_MODE_AUTOREPEAT_ASSERT_SVH

// Checks that a condition implies a consequence at the same clock edge.
`define BMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Button controller assertion failed.");

// Checks that a condition implies a consequence at the next clock edge.
`define BMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Button controller assertion failed.");

`endif

// ===== sv/bma_pkg.sv =====
// Package with types, codes and reset values of the button mode and auto-repeat controller.
package bma_pkg;

    typedef logic [2:0] t_mode;
    typedef logic [2:0] t_action;
    typedef logic [7:0] t_count;
    typedef logic [2:0] t_tally;
    typedef logic [1:0] t_cfg_index;
    typedef logic [7:0] t_cfg_data;

    localparam t_mode MODE_RUN  = 3'd0;
    localparam t_mode MODE_TIME = 3'd1;
    localparam t_mode MODE_ZERO = 3'd5;

    localparam t_action ACTION_NONE = 3'd0;

    localparam t_cfg_index CFG_SLOW_PERIOD   = 2'd0;
    localparam t_cfg_index CFG_FAST_PERIOD   = 2'd1;
    localparam t_cfg_index CFG_ACCEL_REPEATS = 2'd2;

    localparam t_count SLOW_PERIOD_RESET   = 8'd150;
    localparam t_count FAST_PERIOD_RESET   = 8'd75;
    localparam t_tally ACCEL_REPEATS_RESET = 3'd5;

    localparam t_count COUNT_RELOAD = 8'd1;

endpackage

// ===== sv/button_mode_autorepeat.sv =====
// Button scanner with mode selection and accelerating auto-repeat, one result per tick.
// An input transfer goes into the input register and its result into the result register.
// Throughput: one tick per cycle while the output is not stalled, set by the single
// state update between the two registers. Configuration writes are always accepted.
// Reset is synchronous and active low; it clears both valid flags, the repeat tally and
// the color mark, loads the three timers with 1, selects run mode and sets the registers
// to 150, 75 and 5.
module button_mode_autorepeat (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_mode_button_n,
    input  logic                i_lower_button_n,
    input  logic                i_upper_button_n,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_mode,
    output logic                o_mode_changed,
    output logic                o_save_colors,
    output logic                o_rtc_stop,
    output logic [2:0]          o_lower_action,
    output logic                o_bump_hour,
    output logic                o_refresh_time,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  bma_pkg::t_cfg_index i_cfg_index,
    input  bma_pkg::t_cfg_data  i_cfg_data
);
    import bma_pkg::*;

    t_count  r_slow_period;
    t_count  r_fast_period;
    t_tally  r_accel_repeats;

    t_mode   r_cur_mode, n_cur_mode;
    t_count  r_mode_count, n_mode_count;
    t_count  r_lower_count, n_lower_count;
    t_count  r_upper_count, n_upper_count;
    t_tally  r_repeat_tally, n_repeat_tally;
    logic    r_colors_dirty, n_colors_dirty;

    logic    r_in_valid;
    logic    r_in_mode_n;
    logic    r_in_lower_n;
    logic    r_in_upper_n;

    logic    r_out_valid;
    t_mode   r_out_mode;
    logic    r_out_changed, n_changed;
    logic    r_out_save, n_save;
    logic    r_out_stop, n_stop;
    t_action r_out_action, n_action;
    logic    r_out_bump, n_bump;
    logic    r_out_refresh, n_refresh;

    logic    out_ready;
    logic    in_ready;
    logic    step;
    t_count  mode_dec;
    t_count  lower_dec;
    t_count  upper_dec;

    assign out_ready   = !r_out_valid || !i_stall;
    assign in_ready    = !r_in_valid || out_ready;
    assign step        = r_in_valid && out_ready;
    assign o_stall     = !in_ready;
    assign o_cfg_ready = 1'b1;

    assign mode_dec  = r_mode_count - COUNT_RELOAD;
    assign lower_dec = r_lower_count - COUNT_RELOAD;
    assign upper_dec = r_upper_count - COUNT_RELOAD;

    always_comb begin
        n_cur_mode     = r_cur_mode;
        n_mode_count   = r_mode_count;
        n_lower_count  = r_lower_count;
        n_upper_count  = r_upper_count;
        n_repeat_tally = r_repeat_tally;
        n_colors_dirty = r_colors_dirty;
        n_changed      = 1'b0;
        n_save         = 1'b0;
        n_stop         = 1'b0;
        n_action       = ACTION_NONE;
        n_bump         = 1'b0;
        n_refresh      = 1'b0;

        if (!r_in_mode_n) begin
            if (mode_dec == '0) begin
                n_mode_count = r_slow_period;
                n_cur_mode   = (r_cur_mode >= MODE_ZERO) ? MODE_RUN : r_cur_mode + 3'd1;
                n_changed    = 1'b1;
                if (n_cur_mode == MODE_RUN && r_colors_dirty) begin
                    n_colors_dirty = 1'b0;
                    n_save         = 1'b1;
                end
            end else begin
                n_mode_count = mode_dec;
            end
        end else begin
            n_mode_count = COUNT_RELOAD;
        end

        if (n_cur_mode != MODE_RUN) begin
            if (!r_in_lower_n) begin
                if (lower_dec == '0) begin
                    n_stop   = 1'b1;
                    n_action = n_cur_mode;
                    if (r_repeat_tally < r_accel_repeats) begin
                        n_repeat_tally = r_repeat_tally + 3'd1;
                        n_lower_count  = r_slow_period;
                    end else begin
                        n_lower_count = r_fast_period;
                    end
                    if (n_cur_mode != MODE_TIME) begin
                        n_colors_dirty = 1'b1;
                    end
                end else begin
                    n_lower_count = lower_dec;
                end
            end else begin
                n_repeat_tally = '0;
                n_lower_count  = COUNT_RELOAD;
            end

            if (!r_in_upper_n) begin
                if (upper_dec == '0) begin
                    n_stop        = 1'b1;
                    n_bump        = (n_cur_mode == MODE_TIME);
                    n_refresh     = 1'b1;
                    n_upper_count = r_slow_period;
                end else begin
                    n_upper_count = upper_dec;
                end
            end else begin
                n_upper_count = COUNT_RELOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_period   <= SLOW_PERIOD_RESET;
            r_fast_period   <= FAST_PERIOD_RESET;
            r_accel_repeats <= ACCEL_REPEATS_RESET;
            r_cur_mode      <= MODE_RUN;
            r_mode_count    <= COUNT_RELOAD;
            r_lower_count   <= COUNT_RELOAD;
            r_upper_count   <= COUNT_RELOAD;
            r_repeat_tally  <= '0;
            r_colors_dirty  <= 1'b0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SLOW_PERIOD:   r_slow_period   <= i_cfg_data;
                    CFG_FAST_PERIOD:   r_fast_period   <= i_cfg_data;
                    CFG_ACCEL_REPEATS: r_accel_repeats <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_cur_mode     <= n_cur_mode;
                r_mode_count   <= n_mode_count;
                r_lower_count  <= n_lower_count;
                r_upper_count  <= n_upper_count;
                r_repeat_tally <= n_repeat_tally;
                r_colors_dirty <= n_colors_dirty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in_mode_n  <= i_mode_button_n;
            r_in_lower_n <= i_lower_button_n;
            r_in_upper_n <= i_upper_button_n;
        end
        if (step) begin
            r_out_mode    <= n_cur_mode;
            r_out_changed <= n_changed;
            r_out_save    <= n_save;
            r_out_stop    <= n_stop;
            r_out_action  <= n_action;
            r_out_bump    <= n_bump;
            r_out_refresh <= n_refresh;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mode         = r_out_mode;
    assign o_mode_changed = r_out_changed;
    assign o_save_colors  = r_out_save;
    assign o_rtc_stop     = r_out_stop;
    assign o_lower_action = r_out_action;
    assign o_bump_hour    = r_out_bump;
    assign o_refresh_time = r_out_refresh;

endmodule

// ===== sv/bma_checker.sv =====
// Port-level checker for the button mode and auto-repeat controller, with its bind.
`include "button_mode_autorepeat_assert.svh"

module bma_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_mode,
    input logic       o_mode_changed,
    input logic       o_save_colors,
    input logic       o_rtc_stop,
    input logic [2:0] o_lower_action,
    input logic       o_bump_hour,
    input logic       o_refresh_time
);
    import bma_pkg::*;

    // A save pulse only comes with a step back into run mode.
    `BMA_ASSERT_SAME(a_save_on_return, i_clk, i_rst_n, o_valid && o_save_colors, o_mode_changed && o_mode == MODE_RUN)

    // A lower action names the current mode and stops the clock.
    `BMA_ASSERT_SAME(a_action_mode, i_clk, i_rst_n, o_valid && o_lower_action != ACTION_NONE, o_rtc_stop && o_lower_action == o_mode)

    // An hour bump happens only in time mode and always with a refresh.
    `BMA_ASSERT_SAME(a_bump_time, i_clk, i_rst_n, o_valid && o_bump_hour, o_refresh_time && o_mode == MODE_TIME)

    // A refresh comes only from an upper repeat, which also stops the clock.
    `BMA_ASSERT_SAME(a_refresh_stop, i_clk, i_rst_n, o_valid && o_refresh_time, o_rtc_stop && o_mode != MODE_RUN)

    // A stalled result stays offered with its mode unchanged.
    `BMA_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_mode))

endmodule

bind button_mode_autorepeat bma_port_checker u_bma_checker (.*);

// ===== verif/bma_checker.sv =====
// Checker that predicts every tick result of the button controller and compares it field by field.
`timescale 1ns / 100ps
module bma_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick_valid,
    input  logic                i_tick_stall,
    input  logic                i_mode_button_n,
    input  logic                i_lower_button_n,
    input  logic                i_upper_button_n,
    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  logic [2:0]          i_mode,
    input  logic                i_mode_changed,
    input  logic                i_save_colors,
    input  logic                i_rtc_stop,
    input  logic [2:0]          i_lower_action,
    input  logic                i_bump_hour,
    input  logic                i_refresh_time,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  bma_pkg::t_cfg_index i_cfg_index,
    input  bma_pkg::t_cfg_data  i_cfg_data,
    output int                  o_fail_count,
    output int                  o_outstanding
);
    import bma_pkg::*;

    typedef struct packed {
        t_mode   mode;
        logic    changed;
        logic    save;
        logic    stop;
        t_action action;
        logic    bump;
        logic    refresh;
    } tick_outcome_t;

    t_count        slow_ticks;
    t_count        fast_ticks;
    t_tally        accel_limit;
    t_mode         mode_now;
    t_count        mode_timer;
    t_count        lower_timer;
    t_count        upper_timer;
    t_tally        slow_repeats;
    logic          palette_dirty;
    tick_outcome_t outcome_q[$];
    tick_outcome_t want;
    int            result_num;

    task automatic report(input string msg);
        o_fail_count++;
        if (o_fail_count <= 20) begin
            $display("[%0t] result %0d mismatch: %s", $time, result_num, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] exp_val);
        if (got !== exp_val) begin
            report($sformatf("%s is %0d, expected %0d", name, got, exp_val));
        end
    endtask

    function automatic tick_outcome_t scan_buttons(input logic mode_n, input logic lower_n,
                                                   input logic upper_n);
        tick_outcome_t r;
        r = '0;
        r.action = ACTION_NONE;
        if (!mode_n) begin
            mode_timer = mode_timer - 8'd1;
            if (mode_timer == 8'd0) begin
                mode_timer = slow_ticks;
                if (mode_now == MODE_ZERO) begin
                    mode_now = MODE_RUN;
                end else begin
                    mode_now = mode_now + 3'd1;
                end
                r.changed = 1'b1;
                if (mode_now == MODE_RUN && palette_dirty) begin
                    palette_dirty = 1'b0;
                    r.save = 1'b1;
                end
            end
        end else begin
            mode_timer = COUNT_RELOAD;
        end
        if (mode_now != MODE_RUN) begin
            if (!lower_n) begin
                lower_timer = lower_timer - 8'd1;
                if (lower_timer == 8'd0) begin
                    r.stop = 1'b1;
                    if (slow_repeats < accel_limit) begin
                        slow_repeats = slow_repeats + 3'd1;
                        lower_timer = slow_ticks;
                    end else begin
                        lower_timer = fast_ticks;
                    end
                    r.action = mode_now;
                    if (mode_now != MODE_TIME) begin
                        palette_dirty = 1'b1;
                    end
                end
            end else begin
                slow_repeats = '0;
                lower_timer = COUNT_RELOAD;
            end
            if (!upper_n) begin
                upper_timer = upper_timer - 8'd1;
                if (upper_timer == 8'd0) begin
                    r.stop = 1'b1;
                    r.bump = (mode_now == MODE_TIME);
                    r.refresh = 1'b1;
                    upper_timer = slow_ticks;
                end
            end else begin
                upper_timer = COUNT_RELOAD;
            end
        end
        r.mode = mode_now;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slow_ticks    = SLOW_PERIOD_RESET;
            fast_ticks    = FAST_PERIOD_RESET;
            accel_limit   = ACCEL_REPEATS_RESET;
            mode_now      = MODE_RUN;
            mode_timer    = COUNT_RELOAD;
            lower_timer   = COUNT_RELOAD;
            upper_timer   = COUNT_RELOAD;
            slow_repeats  = '0;
            palette_dirty = 1'b0;
            o_fail_count  = 0;
            result_num    = 0;
            outcome_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLOW_PERIOD: begin
                        slow_ticks = i_cfg_data;
                    end
                    CFG_FAST_PERIOD: begin
                        fast_ticks = i_cfg_data;
                    end
                    CFG_ACCEL_REPEATS: begin
                        accel_limit = i_cfg_data[2:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (outcome_q.size() == 0) begin
                    report("result transfer with no tick waiting");
                end else begin
                    want = outcome_q.pop_front();
                    check_field("mode", i_mode, want.mode);
                    check_field("mode_changed", 3'(i_mode_changed), 3'(want.changed));
                    check_field("save_colors", 3'(i_save_colors), 3'(want.save));
                    check_field("rtc_stop", 3'(i_rtc_stop), 3'(want.stop));
                    check_field("lower_action", i_lower_action, want.action);
                    check_field("bump_hour", 3'(i_bump_hour), 3'(want.bump));
                    check_field("refresh_time", 3'(i_refresh_time), 3'(want.refresh));
                end
                result_num++;
            end
            if (i_tick_valid && !i_tick_stall) begin
                outcome_q.push_back(scan_buttons(i_mode_button_n, i_lower_button_n,
                                                 i_upper_button_n));
            end
        end
        o_outstanding = outcome_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the button controller testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module tb_top;
    import bma_pkg::*;

    localparam t_cfg_index CFG_SPARE       = 2'd3;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         HOLD_OFF_CYCLES = 80;
    localparam int         TICKS_PER_PHASE = 130;
    localparam int         PHASE_COUNT     = 7;
    localparam int         STALL_NONE      = 0;
    localparam int         STALL_RANDOM    = 1;
    localparam int         STALL_DUTY      = 2;
    localparam int         OPENING_LEN     = 23;
    localparam logic [3*OPENING_LEN-1:0] OPENING = {
        3'b111, 3'b011, 3'b111, 3'b100, 3'b111, 3'b011, 3'b111, 3'b101,
        3'b011, 3'b111, 3'b110, 3'b011, 3'b111, 3'b011, 3'b101, 3'b111,
        3'b011, 3'b111, 3'b100, 3'b000, 3'b000, 3'b111, 3'b111
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_mode_button_n;
    logic       i_lower_button_n;
    logic       i_upper_button_n;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_mode;
    logic       o_mode_changed;
    logic       o_save_colors;
    logic       o_rtc_stop;
    logic [2:0] o_lower_action;
    logic       o_bump_hour;
    logic       o_refresh_time;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index;
    t_cfg_data  i_cfg_data;

    int fail_count;
    int outstanding;
    int burst_left;
    int idle_cycles;
    bit hold_go;

    button_mode_autorepeat i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode_button_n  (i_mode_button_n),
        .i_lower_button_n (i_lower_button_n),
        .i_upper_button_n (i_upper_button_n),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mode           (o_mode),
        .o_mode_changed   (o_mode_changed),
        .o_save_colors    (o_save_colors),
        .o_rtc_stop       (o_rtc_stop),
        .o_lower_action   (o_lower_action),
        .o_bump_hour      (o_bump_hour),
        .o_refresh_time   (o_refresh_time),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    bma_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick_valid     (i_valid),
        .i_tick_stall     (o_stall),
        .i_mode_button_n  (i_mode_button_n),
        .i_lower_button_n (i_lower_button_n),
        .i_upper_button_n (i_upper_button_n),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_mode           (o_mode),
        .i_mode_changed   (o_mode_changed),
        .i_save_colors    (o_save_colors),
        .i_rtc_stop       (o_rtc_stop),
        .i_lower_action   (o_lower_action),
        .i_bump_hour      (o_bump_hour),
        .i_refresh_time   (o_refresh_time),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic offer_tick(input logic [2:0] buttons);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_mode_button_n  <= buttons[2];
        i_lower_button_n <= buttons[1];
        i_upper_button_n <= buttons[0];
        do @(posedge i_clk); while (o_stall);
        burst_left--;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_cfg_data data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_settings(input t_cfg_data slow, input t_cfg_data fast,
                                 input t_cfg_data accel, input bit poke_spare);
        write_reg(CFG_SLOW_PERIOD, slow);
        write_reg(CFG_FAST_PERIOD, fast);
        write_reg(CFG_ACCEL_REPEATS, accel);
        if (poke_spare) begin
            write_reg(CFG_SPARE, t_cfg_data'($urandom));
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly held button chords of random length, with the odd single-bit glitch.
    task automatic run_random(input int count);
        int         sent;
        int         len;
        logic [2:0] held;
        logic [2:0] buttons;
        sent = 0;
        while (sent < count) begin
            held = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 3) != 0) begin
                held[2] = 1'b1;
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 24);
            repeat (len) begin
                buttons = held;
                if ($urandom_range(0, 15) == 0) begin
                    buttons = held ^ (3'b001 << $urandom_range(0, 2));
                end
                offer_tick(buttons);
                sent++;
            end
        end
    endtask

    initial begin
        int  kind;
        int  len;
        int  step;
        int  on_len;
        int  cycle_len;
        bit  held_off;
        i_stall  = 1'b0;
        held_off = 1'b0;
        forever begin
            if (hold_go && !held_off) begin
                held_off = 1'b1;
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else begin
                kind      = $urandom_range(STALL_NONE, STALL_DUTY);
                len       = $urandom_range(8, 60);
                on_len    = $urandom_range(1, 3);
                cycle_len = on_len + $urandom_range(1, 4);
                for (step = 0; step < len; step++) begin
                    @(negedge i_clk);
                    case (kind)
                        STALL_NONE: begin
                            i_stall <= 1'b0;
                        end
                        STALL_RANDOM: begin
                            i_stall <= ($urandom_range(0, 99) < 40);
                        end
                        default: begin
                            i_stall <= ((step % cycle_len) < on_len);
                        end
                    endcase
                end
            end
        end
    end

    initial begin
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("button_mode_autorepeat verification failed");
        $finish;
    end

    initial begin
        int k;
        int phase;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_mode_button_n  = 1'b1;
        i_lower_button_n = 1'b1;
        i_upper_button_n = 1'b1;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_SLOW_PERIOD;
        i_cfg_data       = '0;
        burst_left       = 0;
        hold_go          = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk every mode under the reset timing, dirty the palette and wrap back to run.
        for (k = 0; k < OPENING_LEN; k++) begin
            offer_tick(OPENING[3*(OPENING_LEN-1-k) +: 3]);
        end
        drain();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    load_settings(8'd1, 8'd1, 8'd0, 1'b0);
                end
                1: begin
                    load_settings(8'd255, 8'd255, 8'd7, 1'b0);
                end
                2: begin
                    load_settings(8'd0, 8'd0, 8'd7, 1'b1);
                end
                3: begin
                    load_settings(8'd3, 8'd2, 8'd2, 1'b0);
                end
                4: begin
                    load_settings(t_cfg_data'($urandom_range(1, 6)),
                                  t_cfg_data'($urandom_range(1, 6)),
                                  t_cfg_data'($urandom_range(0, 255)), 1'b0);
                end
                5: begin
                    load_settings(t_cfg_data'($urandom_range(0, 255)),
                                  t_cfg_data'($urandom_range(0, 255)),
                                  t_cfg_data'($urandom_range(0, 7)), 1'b0);
                end
                default: begin
                    load_settings(8'd2, 8'd1, 8'd7, 1'b0);
                end
            endcase
            if (phase == 0) begin
                hold_go = 1'b1;
            end
            run_random(TICKS_PER_PHASE);
            drain();
        end

        if (fail_count == 0) begin
            $display("button_mode_autorepeat verification clean");
        end else begin
            $display("button_mode_autorepeat verification failed");
        end
        $finish;
    end

endmodule

// ===== button_mode_autorepeat.f =====
+incdir+sv
sv/bma_pkg.sv
sv/button_mode_autorepeat.sv
sv/bma_checker.sv
verif/bma_checker.sv
verif/tb_top.sv
